// File: sv/assert_macros.svh
// Assertion macros used by the checker file of the region byte decoder.
// Depends on nothing; each macro expects signals named clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain implication checked on every rising edge, suspended while reset is held.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// A condition that must hold in every cycle out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	`ASSERT_CLK(label, (expr), msg)

`endif

// File: sv/hbrd_pkg.sv
// Types, codes, constants and lookup functions of the region byte decoder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package hbrd_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int ACC_WIDTH   = 16;
	localparam int CNT_WIDTH   = 4;

	typedef enum logic [1:0] {
		CMD_CHAR = 2'd0,
		CMD_MODE = 2'd1,
		CMD_EOI  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_HEX   = 2'd1,
		MODE_B64   = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		KIND_ABSORB = 3'd0,
		KIND_BYTE   = 3'd1,
		KIND_END    = 3'd2,
		KIND_EOI    = 3'd3,
		KIND_MODE   = 3'd4
	} kind_t;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_BAR   = 8'h7C;
	localparam logic [7:0] CH_BRACE = 8'h7D;
	localparam logic [7:0] CH_PAD   = 8'h3D;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] character;
		logic [1:0] region_width;
	} item_t;

	typedef struct packed {
		mode_t                  mode;
		logic [ACC_WIDTH-1:0]   acc;
		logic [CNT_WIDTH-1:0]   cnt;
		logic [COUNT_WIDTH-1:0] counter;
		logic                   ended;
	} state_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       illegal;
		logic       leftover;
	} result_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] value;
	} digit_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic digit_t hex_digit(input logic [7:0] c);
		digit_t d;
		d = '{ok: 1'b1, value: 6'd0};
		priority if (c >= "0" && c <= "9") d.value = 6'(c - 8'h30);
		else if (c >= "a" && c <= "f") d.value = 6'(c - 8'h57);
		else if (c >= "A" && c <= "F") d.value = 6'(c - 8'h37);
		else d.ok = 1'b0;
		return d;
	endfunction

	function automatic digit_t b64_digit(input logic [7:0] c);
		digit_t d;
		d = '{ok: 1'b1, value: 6'd0};
		priority if (c >= "A" && c <= "Z") d.value = 6'(c - 8'h41);
		else if (c >= "a" && c <= "z") d.value = 6'(c - 8'h47);
		else if (c >= "0" && c <= "9") d.value = 6'(c + 8'h04);
		else if (c == "+") d.value = 6'd62;
		else if (c == "/") d.value = 6'd63;
		else d.ok = 1'b0;
		return d;
	endfunction

endpackage

`default_nettype wire

// File: sv/hbrd_in_stage.sv
// Input register of the region byte decoder: holds one accepted word.
// Depends on hbrd_pkg.
`default_nettype none

module hbrd_in_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	output logic                item_ready,
	input  wire hbrd_pkg::item_t item_in,
	input  wire logic           advance,
	output logic                valid_s1,
	output hbrd_pkg::item_t     item_s1
);

	// The register is free when empty or when its word moves on this cycle.
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item_in;
		end
	end

endmodule

`default_nettype wire

// File: sv/hbrd_decode.sv
// Decode step of the region byte decoder: next state and result for one word.
// Purely combinational; depends on hbrd_pkg.
`default_nettype none

module hbrd_decode (
	input  wire hbrd_pkg::item_t  item,
	input  wire hbrd_pkg::state_t cur,
	output hbrd_pkg::state_t      nxt,
	output hbrd_pkg::result_t     res
);

	localparam int AW = hbrd_pkg::ACC_WIDTH;
	localparam int CW = hbrd_pkg::CNT_WIDTH;

	hbrd_pkg::digit_t digit;
	logic [AW-1:0]    shifted;
	logic [AW-1:0]    acc_new;
	logic [CW-1:0]    cnt_new;
	logic [AW-1:0]    used;
	logic             is_term;
	logic             in_hex;
	logic             in_b64;

	assign in_hex = (cur.mode == hbrd_pkg::MODE_HEX);
	assign in_b64 = (cur.mode == hbrd_pkg::MODE_B64);
	assign digit  = in_hex ? hbrd_pkg::hex_digit(item.character)
	                       : hbrd_pkg::b64_digit(item.character);
	assign shifted = in_hex ? {cur.acc[AW-5:0], 4'b0} : {cur.acc[AW-7:0], 6'b0};
	assign acc_new = shifted | (digit.ok ? AW'(digit.value) : '0);
	assign cnt_new = cur.cnt + (in_hex ? CW'(4) : CW'(6));
	assign used    = ((AW'(1) << cur.cnt) - AW'(1)) & cur.acc;
	assign is_term = (in_b64 && (item.character == hbrd_pkg::CH_BAR ||
	                             item.character == hbrd_pkg::CH_BRACE)) ||
	                 (in_hex && item.character == hbrd_pkg::CH_HASH);

	always_comb begin
		nxt = cur;
		res = '{kind: hbrd_pkg::KIND_ABSORB, data: 8'd0, illegal: 1'b0, leftover: 1'b0};
		if (cur.ended) begin
			nxt.mode = hbrd_pkg::MODE_PLAIN;
			res.kind = hbrd_pkg::KIND_EOI;
		end else begin
			unique case (item.command)
				hbrd_pkg::CMD_EOI: begin
					nxt.ended = 1'b1;
					res.kind  = hbrd_pkg::KIND_EOI;
				end
				hbrd_pkg::CMD_MODE: begin
					if (item.region_width == hbrd_pkg::MODE_HEX ||
					    item.region_width == hbrd_pkg::MODE_B64) begin
						nxt.mode = hbrd_pkg::mode_t'(item.region_width);
					end else begin
						nxt.mode = hbrd_pkg::MODE_PLAIN;
					end
					nxt.acc  = '0;
					nxt.cnt  = '0;
					res.kind = hbrd_pkg::KIND_MODE;
				end
				hbrd_pkg::CMD_CHAR: begin
					priority if (is_term) begin
						res.leftover = (cur.cnt != '0) && (used != '0);
						nxt.mode     = hbrd_pkg::MODE_PLAIN;
						nxt.acc      = '0;
						nxt.cnt      = '0;
						res.kind     = hbrd_pkg::KIND_END;
						res.data     = item.character;
					end else if (cur.mode != hbrd_pkg::MODE_PLAIN &&
					             hbrd_pkg::is_space(item.character)) begin
						res.kind = hbrd_pkg::KIND_ABSORB;
					end else if (in_b64 && item.character == hbrd_pkg::CH_PAD) begin
						res.kind = hbrd_pkg::KIND_ABSORB;
					end else if (cur.mode == hbrd_pkg::MODE_PLAIN) begin
						nxt.counter = cur.counter + 1'b1;
						res.kind    = hbrd_pkg::KIND_BYTE;
						res.data    = item.character;
					end else begin
						nxt.acc     = acc_new;
						nxt.cnt     = cnt_new;
						res.illegal = !digit.ok;
						if (cnt_new >= CW'(8)) begin
							res.data    = 8'(acc_new >> (cnt_new - CW'(8)));
							nxt.cnt     = cnt_new - CW'(8);
							nxt.counter = cur.counter + 1'b1;
							res.kind    = hbrd_pkg::KIND_BYTE;
						end
					end
				end
				default: begin
					res.kind = hbrd_pkg::KIND_ABSORB;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: sv/hbrd_out_stage.sv
// Decoder state registers and the result register of the region byte decoder.
// Depends on hbrd_pkg.
`default_nettype none

module hbrd_out_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire hbrd_pkg::state_t nxt,
	input  wire hbrd_pkg::result_t res,
	input  wire logic             result_ready,
	output hbrd_pkg::state_t      state_q,
	output logic                  valid_s2,
	output hbrd_pkg::result_t     res_s2,
	output logic [31:0]           index_s2
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode    <= hbrd_pkg::MODE_PLAIN;
			state_q.acc     <= '0;
			state_q.cnt     <= '0;
			state_q.counter <= '1;
			state_q.ended   <= 1'b0;
			valid_s2        <= 1'b0;
		end else if (advance) begin
			state_q  <= nxt;
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2   <= res;
			index_s2 <= 32'(nxt.counter);
		end
	end

endmodule

`default_nettype wire

// File: sv/hex_base64_region_byte_decoder.sv
// Top level of the region byte decoder: input register, decode step, result register.
// Depends on hbrd_pkg, hbrd_in_stage, hbrd_decode and hbrd_out_stage.
//
//   channel  handshake                   words carried
//   -------  --------------------------  ------------------------------------------
//   item     item_valid / item_ready     command, character, region_width
//   result   result_valid / result_ready result_kind, data_byte, byte_index,
//                                        illegal_char, leftover_bits
//
// Every accepted word gives exactly one result word, through the input and result registers.
// A new word is taken in every cycle while results are drained; the rate of one
// per cycle is set by the single decode step between the two registers.
// When result_ready is low the result register holds and the input register fills,
// after which item_ready drops; nothing is lost or repeated.
// Reset clears the mode to plain, the accumulator and bit count to zero, the byte
// counter to all ones and the end-of-input flag; both registers come up empty.
`default_nettype none

module hex_base64_region_byte_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [1:0]  command,
	input  wire logic [7:0]  character,
	input  wire logic [1:0]  region_width,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [2:0]       result_kind,
	output logic [7:0]       data_byte,
	output logic [31:0]      byte_index,
	output logic             illegal_char,
	output logic             leftover_bits
);

	hbrd_pkg::item_t   item_in;
	hbrd_pkg::item_t   item_s1;
	logic              valid_s1;
	logic              advance;
	hbrd_pkg::state_t  state_q;
	hbrd_pkg::state_t  nxt;
	hbrd_pkg::result_t res;
	hbrd_pkg::result_t res_s2;

	assign item_in = '{command: command, character: character, region_width: region_width};

	// The word in the input register is decoded, and the state updated, in the
	// cycle in which the result register is empty or its word is being taken.
	// Decoding and the state update happen together, so the next word always
	// sees the state this one leaves.
	assign advance = valid_s1 && (!result_valid || result_ready);

	hbrd_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item_in    (item_in),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	// Whitespace and padding skipping, digit lookup, the shift into the
	// accumulator and the byte extraction all sit in this one step.
	hbrd_decode u_dec (
		.item (item_s1),
		.cur  (state_q),
		.nxt  (nxt),
		.res  (res)
	);

	hbrd_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.nxt          (nxt),
		.res          (res),
		.result_ready (result_ready),
		.state_q      (state_q),
		.valid_s2     (result_valid),
		.res_s2       (res_s2),
		.index_s2     (byte_index)
	);

	assign result_kind   = res_s2.kind;
	assign data_byte     = res_s2.data;
	assign illegal_char  = res_s2.illegal;
	assign leftover_bits = res_s2.leftover;

endmodule

`default_nettype wire

// File: sv/hbrd_checker.sv
// Port-level checks of the region byte decoder, bound to its top level.
// Depends on hbrd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hbrd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        result_valid,
	input wire logic        result_ready,
	input wire logic [2:0]  result_kind,
	input wire logic [7:0]  data_byte,
	input wire logic        illegal_char,
	input wire logic        leftover_bits
);

	`ASSERT_CLK(a_result_holds, result_valid && !result_ready |=> result_valid && $stable(result_kind) && $stable(data_byte), "result word changed while stalled")
	`ASSERT_ALWAYS(a_leftover_end, !(result_valid && leftover_bits) || result_kind == hbrd_pkg::KIND_END, "leftover flag outside a region end")
	`ASSERT_ALWAYS(a_illegal_kind, !(result_valid && illegal_char) || result_kind == hbrd_pkg::KIND_ABSORB || result_kind == hbrd_pkg::KIND_BYTE, "illegal flag on a word that takes no digit")
	`ASSERT_ALWAYS(a_data_zero, !(result_valid && (result_kind == hbrd_pkg::KIND_ABSORB || result_kind == hbrd_pkg::KIND_EOI || result_kind == hbrd_pkg::KIND_MODE)) || data_byte == 8'd0, "data byte set on a word without data")

endmodule

bind hex_base64_region_byte_decoder hbrd_checker u_hbrd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_valid  (result_valid),
	.result_ready  (result_ready),
	.result_kind   (result_kind),
	.data_byte     (data_byte),
	.illegal_char  (illegal_char),
	.leftover_bits (leftover_bits)
);

`default_nettype wire

// File: tb/hbrd_tb_pkg.sv
// Scoreboard for the region byte decoder testbench: a predictor of the decode
// behaviour and a queue of awaited result words. Depends on hbrd_pkg.
package hbrd_tb_pkg;

	import hbrd_pkg::*;

	// Codes that the package leaves unnamed but the fields can still carry.
	localparam logic [1:0] CMD_UNUSED   = 2'd3;
	localparam logic [1:0] WIDTH_UNUSED = 2'd3;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [31:0] index;
		logic        illegal;
		logic        leftover;
	} outcome_t;

	class region_decode_scoreboard;

		mode_t                  mode;
		logic [ACC_WIDTH-1:0]   acc;
		logic [CNT_WIDTH-1:0]   nbits;
		logic [COUNT_WIDTH-1:0] delivered;
		logic                   ended;
		outcome_t               awaited[$];
		int                     errors;
		int                     checked;
		int                     bytes_seen;

		function new();
			mode = MODE_PLAIN;
			acc = '0;
			nbits = '0;
			delivered = '1;
			ended = 1'b0;
			errors = 0;
			checked = 0;
			bytes_seen = 0;
		endfunction

		function bit is_blank(logic [7:0] c);
			case (c)
				8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		// Value of a digit in the given coding, or -1 when it is not one.
		function int digit_of(mode_t m, logic [7:0] c);
			if (m == MODE_HEX) begin
				if (c >= "0" && c <= "9") return int'(c) - int'("0");
				if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
				if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
				return -1;
			end
			if (c >= "A" && c <= "Z") return int'(c) - int'("A");
			if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
			if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
			if (c == "+") return 62;
			if (c == "/") return 63;
			return -1;
		endfunction

		function void note_item(logic [1:0] cmd, logic [7:0] ch, logic [1:0] rw);
			outcome_t o;
			int       v;
			int       w;
			o = '{kind: KIND_ABSORB, data: 8'h00, index: '0, illegal: 1'b0, leftover: 1'b0};
			if (ended) begin
				mode = MODE_PLAIN;
				o.kind = KIND_EOI;
			end else if (cmd == CMD_EOI) begin
				ended = 1'b1;
				o.kind = KIND_EOI;
			end else if (cmd == CMD_MODE) begin
				mode = (rw == WIDTH_UNUSED) ? MODE_PLAIN : mode_t'(rw);
				acc = '0;
				nbits = '0;
				o.kind = KIND_MODE;
			end else if (cmd == CMD_CHAR) begin
				if ((mode == MODE_B64 && (ch == CH_BAR || ch == CH_BRACE)) ||
				    (mode == MODE_HEX && ch == CH_HASH)) begin
					// Only the bits still waiting to form a byte are looked at.
					o.leftover = |(acc & ((16'd1 << nbits) - 16'd1));
					mode = MODE_PLAIN;
					acc = '0;
					nbits = '0;
					o.kind = KIND_END;
					o.data = ch;
				end else if (mode != MODE_PLAIN && is_blank(ch)) begin
					o.kind = KIND_ABSORB;
				end else if (mode == MODE_B64 && ch == CH_PAD) begin
					o.kind = KIND_ABSORB;
				end else if (mode == MODE_PLAIN) begin
					delivered = delivered + 1'b1;
					o.kind = KIND_BYTE;
					o.data = ch;
				end else begin
					w = (mode == MODE_HEX) ? 4 : 6;
					v = digit_of(mode, ch);
					acc = acc << w;
					nbits = nbits + 4'(w);
					if (v >= 0)
						acc = acc | 16'(v);
					else
						o.illegal = 1'b1;
					if (nbits >= 4'd8) begin
						o.data = 8'(acc >> (nbits - 4'd8));
						nbits = nbits - 4'd8;
						delivered = delivered + 1'b1;
						o.kind = KIND_BYTE;
					end
				end
			end
			o.index = delivered[31:0];
			awaited.insert(awaited.size(), o);
		endfunction

		function int field_diff(string name, logic [31:0] want, logic [31:0] got, realtime at);
			if (want !== got) begin
				$display("%0.1f ns: %s expected %0h, got %0h", at, name, want, got);
				return 1;
			end
			return 0;
		endfunction

		function void check_result(logic [2:0] kind, logic [7:0] data, logic [31:0] index,
				logic illegal, logic leftover, realtime at);
			outcome_t e;
			if (awaited.size() == 0) begin
				$display("%0.1f ns: result word with nothing awaited, expected none, got kind %0d data %0h",
					at, kind, data);
				errors++;
				return;
			end
			e = awaited.pop_front();
			checked++;
			if (e.kind == KIND_BYTE)
				bytes_seen++;
			errors += field_diff("result_kind", e.kind, kind, at);
			errors += field_diff("data_byte", e.data, data, at);
			errors += field_diff("byte_index", e.index, index, at);
			errors += field_diff("illegal_char", e.illegal, illegal, at);
			errors += field_diff("leftover_bits", e.leftover, leftover, at);
		endfunction

		function int pending();
			return awaited.size();
		endfunction

	endclass

endpackage

// File: tb/tb_hex_base64_region_byte_decoder.sv
// Self-checking testbench of hex_base64_region_byte_decoder: directed and random
// character streams over plain, hex and base64 regions. Depends on hbrd_pkg and hbrd_tb_pkg.
module tb_hex_base64_region_byte_decoder;

	timeunit 1ns;
	timeprecision 1ps;

	import hbrd_pkg::*;
	import hbrd_tb_pkg::*;

	localparam int IDLE_LIMIT  = 2000; // cycles with no word moving on either side
	localparam int LONG_HOLD   = 80;   // receiver hold-off, well beyond the two-deep pipeline
	localparam int HOLD_AFTER  = 400;  // results checked before the long hold-off starts
	localparam int ITEM_TARGET = 1450;
	localparam int SETTLE      = 8;    // margin after the drain for stray words

	logic        clk = 1'b0;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	logic [1:0]  command;
	logic [7:0]  character;
	logic [1:0]  region_width;
	logic        result_valid;
	logic        result_ready;
	logic [2:0]  result_kind;
	logic [7:0]  data_byte;
	logic [31:0] byte_index;
	logic        illegal_char;
	logic        leftover_bits;

	region_decode_scoreboard board = new();

	// When calm is set, neither side inserts gaps, so the block runs at full rate.
	bit calm = 1'b0;
	bit held_long = 1'b0;
	int sent_items = 0;
	int idle_cycles = 0;

	hex_base64_region_byte_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.command      (command),
		.character    (character),
		.region_width (region_width),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_kind  (result_kind),
		.data_byte    (data_byte),
		.byte_index   (byte_index),
		.illegal_char (illegal_char),
		.leftover_bits(leftover_bits)
	);

	always #1 clk = ~clk;

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offers one word and returns at the edge where it is taken. The valid line
	// is left high so that the next word can follow back to back; a gap lowers it
	// in the same step instead, so valid sees a single assignment per step.
	task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch, input logic [1:0] rw);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		command <= cmd;
		character <= ch;
		region_width <= rw;
		do @(posedge clk); while (!item_ready);
		board.note_item(cmd, ch, rw);
		sent_items++;
	endtask

	// The sender stands back until every awaited result word has come out.
	task automatic drain();
		item_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] hex_char();
		int r;
		r = $urandom_range(0, 21);
		if (r < 10) return 8'("0" + r);
		if (r < 16) return 8'("a" + r - 10);
		return 8'("A" + r - 16);
	endfunction

	function automatic logic [7:0] b64_char();
		int r;
		r = $urandom_range(0, 63);
		if (r < 26) return 8'("A" + r);
		if (r < 52) return 8'("a" + r - 26);
		if (r < 62) return 8'("0" + r - 52);
		return (r == 62) ? 8'("+") : 8'("/");
	endfunction

	function automatic logic [7:0] blank_char();
		int r;
		r = $urandom_range(0, 5);
		return (r == 0) ? 8'h20 : 8'(8'h08 + r);
	endfunction

	// One stretch of stimulus: a plain run, a hex or base64 region with random
	// content, or a few words of noise. Most regions are closed properly; some are
	// abandoned by the next mode word, and the noise may cut them short.
	task automatic send_sequence();
		int r;
		int p;
		int len;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			send_item(CMD_MODE, 8'($urandom), $urandom_range(0, 1) ? MODE_PLAIN : WIDTH_UNUSED);
			len = $urandom_range(1, 6);
			repeat (len) send_item(CMD_CHAR, 8'($urandom_range(0, 255)), 2'($urandom));
		end else if (r < 50) begin
			send_item(CMD_MODE, 8'($urandom), MODE_HEX);
			len = $urandom_range(0, 12);
			repeat (len) begin
				p = $urandom_range(0, 99);
				if (p < 80)
					send_item(CMD_CHAR, hex_char(), 2'($urandom));
				else if (p < 92)
					send_item(CMD_CHAR, blank_char(), 2'($urandom));
				else
					send_item(CMD_CHAR, 8'($urandom_range(0, 255)), 2'($urandom));
			end
			if ($urandom_range(0, 99) < 80)
				send_item(CMD_CHAR, CH_HASH, 2'($urandom));
		end else if (r < 85) begin
			send_item(CMD_MODE, 8'($urandom), MODE_B64);
			len = $urandom_range(0, 16);
			repeat (len) begin
				p = $urandom_range(0, 99);
				if (p < 75)
					send_item(CMD_CHAR, b64_char(), 2'($urandom));
				else if (p < 83)
					send_item(CMD_CHAR, CH_PAD, 2'($urandom));
				else if (p < 92)
					send_item(CMD_CHAR, blank_char(), 2'($urandom));
				else
					send_item(CMD_CHAR, 8'($urandom_range(0, 255)), 2'($urandom));
			end
			if ($urandom_range(0, 99) < 85)
				send_item(CMD_CHAR, $urandom_range(0, 1) ? CH_BAR : CH_BRACE, 2'($urandom));
		end else begin
			len = $urandom_range(1, 4);
			repeat (len) begin
				p = $urandom_range(0, 2);
				send_item((p == 0) ? CMD_CHAR : (p == 1) ? CMD_MODE : CMD_UNUSED,
					8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
			end
		end
	endtask

	// Receiver: checks each word taken, then picks ready for the next edge. Once,
	// after a few hundred results, it holds ready low for a long stretch while the
	// sender keeps offering, so that both pipeline registers fill and item_ready drops.
	initial begin
		int stall_left;
		stall_left = 0;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_valid && result_ready)
				board.check_result(result_kind, data_byte, byte_index, illegal_char,
					leftover_bits, $realtime);
			if (!held_long && board.checked >= HOLD_AFTER) begin
				held_long = 1'b1;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else begin
				stall_left = pick_gap();
				result_ready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// Watchdog: a run that stops moving words in either direction has hung.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("hex_base64_region_byte_decoder test failed");
			$finish;
		end
	end

	initial begin
		int phase;
		arst_n = 1'b0;
		item_valid = 1'b0;
		command = CMD_CHAR;
		character = 8'h00;
		region_width = MODE_PLAIN;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. Plain mode passes every byte, the extremes and a hash too;
		// the first byte wraps the counter from all ones to zero.
		send_item(CMD_CHAR, 8'h00, MODE_PLAIN);
		send_item(CMD_CHAR, 8'hFF, WIDTH_UNUSED);
		send_item(CMD_CHAR, CH_HASH, MODE_PLAIN);
		// Hex: both letter cases, a skipped blank, an illegal digit that adds zero
		// bits, and a region closed with a digit still waiting.
		send_item(CMD_MODE, 8'hFF, MODE_HEX);
		send_item(CMD_CHAR, "F", MODE_PLAIN);
		send_item(CMD_CHAR, "f", MODE_PLAIN);
		send_item(CMD_CHAR, 8'h20, MODE_PLAIN);
		send_item(CMD_CHAR, "g", MODE_PLAIN);
		send_item(CMD_CHAR, "A", MODE_PLAIN);
		send_item(CMD_CHAR, "9", MODE_PLAIN);
		send_item(CMD_CHAR, CH_HASH, MODE_PLAIN);
		// Base64: padding and a carriage return are skipped, an illegal digit
		// completes a byte with the flag set, and a bar closes with zero bits left.
		send_item(CMD_MODE, 8'h00, MODE_B64);
		send_item(CMD_CHAR, "/", MODE_PLAIN);
		send_item(CMD_CHAR, "/", MODE_PLAIN);
		send_item(CMD_CHAR, CH_PAD, MODE_PLAIN);
		send_item(CMD_CHAR, 8'h0D, MODE_PLAIN);
		send_item(CMD_CHAR, "*", MODE_PLAIN);
		send_item(CMD_CHAR, CH_BAR, MODE_PLAIN);
		send_item(CMD_CHAR, CH_PAD, MODE_PLAIN);
		// A brace closes base64 with set bits left over.
		send_item(CMD_MODE, 8'h00, MODE_B64);
		send_item(CMD_CHAR, "+", MODE_PLAIN);
		send_item(CMD_CHAR, CH_BRACE, MODE_PLAIN);
		// The unused width code selects plain; the unused command does nothing;
		// a mode word drops a half-built byte.
		send_item(CMD_MODE, 8'h00, WIDTH_UNUSED);
		send_item(CMD_UNUSED, "A", MODE_HEX);
		send_item(CMD_MODE, 8'h00, MODE_HEX);
		send_item(CMD_CHAR, "0", MODE_PLAIN);
		send_item(CMD_MODE, 8'h00, MODE_PLAIN);
		drain();

		// Random part in phases; some run without gaps, and every third one ends
		// with the sender waiting until the block has emptied.
		phase = 0;
		while (sent_items < ITEM_TARGET) begin
			calm = (phase % 5 == 4);
			repeat (12) send_sequence();
			if (phase % 3 == 2)
				drain();
			phase++;
		end
		calm = 1'b0;

		// End of input, then one word of every command: all must report end of input.
		send_item(CMD_EOI, 8'($urandom), 2'($urandom));
		send_item(CMD_CHAR, "A", MODE_PLAIN);
		send_item(CMD_MODE, 8'h00, MODE_B64);
		send_item(CMD_CHAR, CH_BAR, MODE_PLAIN);
		send_item(CMD_UNUSED, 8'hFF, WIDTH_UNUSED);
		send_item(CMD_EOI, 8'h00, MODE_HEX);
		drain();
		repeat (SETTLE) @(posedge clk);

		$display("Checked %0d result words (%0d bytes) from %0d input words over plain, hex",
			board.checked, board.bytes_seen, sent_items);
		$display("and base64 regions, with a long receiver hold-off and end-of-input handling.");
		if (board.errors == 0 && board.pending() == 0) begin
			$display("hex_base64_region_byte_decoder test passed");
		end else begin
			$display("hex_base64_region_byte_decoder test failed");
		end
		$finish;
	end

endmodule
